// ===== src/sdht_pkg.sv =====
// shared constants, types and helpers for the string dedup hash table
package sdht_pkg;

	localparam int MEM_BYTES     = 65536;
	localparam int TABLE_ENTRIES = 4096;
	localparam int HASH_BUCKETS  = 4093;
	localparam int MAX_LEN       = 256;

	localparam int MEM_AW = $clog2(MEM_BYTES);
	localparam int END_W  = $clog2(MEM_BYTES + 1);
	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int ENT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int BKT_W  = $clog2(HASH_BUCKETS);
	localparam int LEN_W  = $clog2(MAX_LEN + 2);
	localparam int STG_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W  = 16;
	localparam int HASH_W = 32;
	// 2^BKT_W mod HASH_BUCKETS, weight of the bits above BKT_W when folding
	localparam int FOLD_K = (1 << BKT_W) - HASH_BUCKETS;

	localparam logic [7:0] HDR_BYTE  = 8'h0a;
	localparam logic [7:0] VAR_MASK  = 8'h7f;
	localparam logic [7:0] VAR_MORE  = 8'h80;
	localparam int         HDR_SLACK = 10;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [2:0] ST_NEW   = 3'd0;
	localparam logic [2:0] ST_FOUND = 3'd1;
	localparam logic [2:0] ST_TFULL = 3'd2;
	localparam logic [2:0] ST_MFULL = 3'd3;
	localparam logic [2:0] ST_LONG  = 3'd4;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [MEM_AW-1:0] off;
		logic [ENT_W-1:0]  link;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_READ, S_READ_WT, S_HASH, S_HEAD_RD, S_HEAD_WT,
		S_ENT_RD, S_ENT_WT, S_CMP_RD, S_CMP_WT, S_HIT, S_CHECK,
		S_WR_HDR, S_WR_LEN, S_CPY_RD, S_CPY_WR, S_DONE
	} state_t;

	// byte shift for the hash, cycling with position mod 7
	function automatic logic [4:0] hash_shift(input logic [2:0] pos);
		logic [4:0] s;
		case (pos)
			3'd0: s = 5'd0;
			3'd1: s = 5'd8;
			3'd2: s = 5'd16;
			3'd3: s = 5'd24;
			3'd4: s = 5'd4;
			3'd5: s = 5'd12;
			3'd6: s = 5'd20;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== src/sdht_ram.sv =====
// generic simple dual port ram with registered read
module sdht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/string_dedup_hash_table.sv =====
// top level of the string dedup hash table
//
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    opcode, data_byte, read_address
// out      out  out_valid/out_stall  string_index, status, occurrence_count,
//                                    used_bytes, read_byte
//
// an append request is taken without leaving idle, a memory read passes S_READ
// and S_READ_WT, a clear sweeps the buckets (one bucket head written per cycle)
// an end request first finds the bucket remainder (folds of the hash by 2^12 mod
// HASH_BUCKETS, then one compare and subtract), then reads each chain entry and
// compares its bytes one by one, and on insert writes the header and the length
// bytes, then copies the staged bytes; all memories have one read port
// after reset the same clearing sweep runs before the first request is taken;
// in_stall stays high while a request is in work
// a finished result waits in the output register while out_stall is high
module string_dedup_hash_table import sdht_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       opcode,
	input  logic [7:0]       data_byte,
	input  logic [15:0]      read_address,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [IDX_W-1:0] string_index,
	output logic [2:0]       status,
	output logic [15:0]      occurrence_count,
	output logic [END_W-1:0] used_bytes,
	output logic [7:0]       read_byte
);
	state_t state_q, state_d;

	// control and staging registers
	logic [1:0]        op_q;
	logic [MEM_AW-1:0] addr_q;
	logic [BKT_W-1:0]  clr_q;
	logic [ENT_W-1:0]  used_q;
	logic [END_W-1:0]  end_q;
	logic [HASH_W-1:0] hash_q;
	logic [LEN_W-1:0]  len_q;
	logic [2:0]        pos7_q;
	logic [HASH_W-1:0] red_q;
	logic [BKT_W-1:0]  rem_q;
	logic [ENT_W-1:0]  head_q;
	logic [ENT_W-1:0]  e_q;
	entry_t            ent_q;
	logic [LEN_W-1:0]  i_q;
	logic [LEN_W-1:0]  v_q;

	// pending result
	logic [IDX_W-1:0]  res_idx_q;
	logic [2:0]        res_st_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [7:0]        res_rb_q;

	// output register
	logic              out_valid_q;

	// ram ports
	logic              mem_we, stg_we, bkt_we, ent_we;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;
	logic [STG_AW-1:0] stg_waddr, stg_raddr;
	logic [7:0]        stg_rdata;
	logic [BKT_W-1:0]  bkt_waddr, bkt_raddr;
	logic [ENT_W-1:0]  bkt_wdata, bkt_rdata;
	logic [IDX_W-1:0]  ent_waddr, ent_raddr;
	entry_t            ent_wdata;
	logic [$bits(entry_t)-1:0] ent_rdata;
	entry_t            ent_rd;

	logic              accept, out_take, done_go;
	logic [HASH_W-1:0] fold_sum;
	logic              fold_done;
	logic [END_W:0]    cmp_addr;
	logic [END_W+1:0]  need_end;
	logic              last_byte;
	logic [7:0]        var_byte;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_take = out_valid_q && !out_stall;
	assign done_go  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign ent_rd   = entry_t'(ent_rdata);

	// bucket remainder step: bits above BKT_W fold back with weight FOLD_K
	assign fold_sum  = (red_q >> BKT_W) * HASH_W'(FOLD_K) + HASH_W'(red_q[BKT_W-1:0]);
	assign fold_done = (red_q[HASH_W-1:BKT_W] == '0);
	assign cmp_addr  = (END_W + 1)'(ent_q.off) + (END_W + 1)'(i_q);
	assign need_end  = (END_W + 2)'(len_q) + (END_W + 2)'(HDR_SLACK) + (END_W + 2)'(end_q);
	assign last_byte = ((i_q + 1'b1) == len_q);
	assign var_byte  = (v_q > LEN_W'(VAR_MASK)) ? ((8'(v_q) & VAR_MASK) | VAR_MORE) : 8'(v_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_CLEAR:  state_d = S_CLEAR;
						OP_APPEND: state_d = S_IDLE;
						OP_END:    state_d = (len_q > LEN_W'(MAX_LEN)) ? S_DONE : S_HASH;
						OP_READ:   state_d = S_READ;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR:   state_d = (clr_q == BKT_W'(HASH_BUCKETS - 1)) ? S_IDLE : S_CLEAR;
			S_READ:    state_d = S_READ_WT;
			S_READ_WT: state_d = S_DONE;
			S_HASH:    state_d = fold_done ? S_HEAD_RD : S_HASH;
			S_HEAD_RD: state_d = S_HEAD_WT;
			S_HEAD_WT: state_d = S_ENT_RD;
			S_ENT_RD:  state_d = (e_q == '0 || e_q >= ENT_W'(TABLE_ENTRIES)) ? S_CHECK : S_ENT_WT;
			S_ENT_WT: begin
				if (ent_rd.len != len_q) begin
					state_d = S_ENT_RD;
				end else if (len_q == '0) begin
					state_d = S_HIT;
				end else begin
					state_d = S_CMP_RD;
				end
			end
			S_CMP_RD:  state_d = S_CMP_WT;
			S_CMP_WT: begin
				if (cmp_addr >= (END_W + 1)'(MEM_BYTES) || mem_rdata != stg_rdata) begin
					state_d = S_ENT_RD;
				end else if (last_byte) begin
					state_d = S_HIT;
				end else begin
					state_d = S_CMP_RD;
				end
			end
			S_HIT:     state_d = S_DONE;
			S_CHECK: begin
				if (used_q >= ENT_W'(TABLE_ENTRIES)) begin
					state_d = S_DONE;
				end else if (need_end > (END_W + 2)'(MEM_BYTES)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WR_HDR;
				end
			end
			S_WR_HDR:  state_d = S_WR_LEN;
			S_WR_LEN: begin
				if (v_q > LEN_W'(VAR_MASK)) begin
					state_d = S_WR_LEN;
				end else if (len_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CPY_RD;
				end
			end
			S_CPY_RD:  state_d = S_CPY_WR;
			S_CPY_WR:  state_d = last_byte ? S_DONE : S_CPY_RD;
			S_DONE:    state_d = done_go ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = end_q[MEM_AW-1:0];
		mem_wdata = HDR_BYTE;
		mem_raddr = addr_q;
		stg_we    = 1'b0;
		stg_waddr = len_q[STG_AW-1:0];
		stg_raddr = i_q[STG_AW-1:0];
		bkt_we    = 1'b0;
		bkt_waddr = rem_q;
		bkt_wdata = used_q;
		bkt_raddr = rem_q;
		ent_we    = 1'b0;
		ent_waddr = e_q[IDX_W-1:0];
		ent_wdata = ent_q;
		ent_raddr = e_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				// staged byte lands at the current length
				stg_we = accept && (opcode == OP_APPEND) && (data_byte != 8'd0)
					&& (len_q < LEN_W'(MAX_LEN));
			end
			S_CLEAR: begin
				bkt_we    = 1'b1;
				bkt_waddr = clr_q;
				bkt_wdata = '0;
				// reserved empty string at the start of memory
				mem_we    = (clr_q < BKT_W'(2));
				mem_waddr = MEM_AW'(clr_q);
				mem_wdata = (clr_q == '0) ? HDR_BYTE : 8'd0;
			end
			S_CMP_RD: begin
				mem_raddr = cmp_addr[MEM_AW-1:0];
			end
			S_HIT: begin
				ent_we    = 1'b1;
				ent_wdata = ent_q;
				if (ent_q.cnt != {CNT_W{1'b1}}) begin
					ent_wdata.cnt = ent_q.cnt + 1'b1;
				end
			end
			S_WR_HDR: begin
				mem_we = 1'b1;
				bkt_we = 1'b1;
			end
			S_WR_LEN: begin
				mem_we    = 1'b1;
				mem_wdata = var_byte;
				if (v_q <= LEN_W'(VAR_MASK)) begin
					ent_we         = 1'b1;
					ent_waddr      = used_q[IDX_W-1:0];
					ent_wdata.len  = len_q;
					ent_wdata.off  = MEM_AW'(end_q + 1'b1);
					ent_wdata.link = head_q;
					ent_wdata.cnt  = CNT_W'(1);
				end
			end
			S_CPY_WR: begin
				mem_we    = 1'b1;
				mem_wdata = stg_rdata;
			end
			default: begin
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_q      <= ENT_W'(1);
			end_q       <= END_W'(2);
			hash_q      <= '0;
			len_q       <= '0;
			pos7_q      <= '0;
			op_q        <= OP_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= opcode;
						addr_q    <= MEM_AW'(read_address);
						res_idx_q <= '0;
						res_cnt_q <= '0;
						res_rb_q  <= '0;
						res_st_q  <= ST_LONG;
						red_q     <= hash_q;
						rem_q     <= '0;
						clr_q     <= '0;
						if (opcode == OP_CLEAR) begin
							used_q <= ENT_W'(1);
							end_q  <= END_W'(2);
							hash_q <= '0;
							len_q  <= '0;
							pos7_q <= '0;
						end
						if (opcode == OP_APPEND && data_byte != 8'd0
							&& len_q <= LEN_W'(MAX_LEN)) begin
							if (len_q < LEN_W'(MAX_LEN)) begin
								hash_q <= hash_q + (HASH_W'(data_byte) << hash_shift(pos7_q));
							end
							pos7_q <= (pos7_q == 3'd6) ? 3'd0 : pos7_q + 1'b1;
							len_q  <= len_q + 1'b1;
						end
					end
				end
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_READ_WT: begin
					res_st_q <= ST_NEW;
					res_rb_q <= mem_rdata;
				end
				S_HASH: begin
					// fold until the upper bits are gone, then one subtract at most
					if (fold_done) begin
						rem_q <= (red_q[BKT_W-1:0] >= BKT_W'(HASH_BUCKETS))
							? red_q[BKT_W-1:0] - BKT_W'(HASH_BUCKETS) : red_q[BKT_W-1:0];
					end else begin
						red_q <= fold_sum;
					end
				end
				S_HEAD_WT: begin
					head_q <= bkt_rdata;
					e_q    <= bkt_rdata;
				end
				S_ENT_WT: begin
					ent_q <= ent_rd;
					i_q   <= '0;
					if (ent_rd.len != len_q) begin
						e_q <= ent_rd.link;
					end
				end
				S_CMP_WT: begin
					if (cmp_addr >= (END_W + 1)'(MEM_BYTES) || mem_rdata != stg_rdata) begin
						e_q <= ent_q.link;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_HIT: begin
					res_idx_q <= IDX_W'(e_q);
					res_st_q  <= ST_FOUND;
					res_cnt_q <= (ent_q.cnt != {CNT_W{1'b1}}) ? ent_q.cnt + 1'b1 : ent_q.cnt;
				end
				S_CHECK: begin
					res_st_q <= (used_q >= ENT_W'(TABLE_ENTRIES)) ? ST_TFULL : ST_MFULL;
					v_q      <= len_q;
					i_q      <= '0;
				end
				S_WR_HDR: end_q <= end_q + 1'b1;
				S_WR_LEN: begin
					end_q <= end_q + 1'b1;
					v_q   <= v_q >> 7;
					if (v_q <= LEN_W'(VAR_MASK)) begin
						res_idx_q <= IDX_W'(used_q);
						res_st_q  <= ST_NEW;
						res_cnt_q <= CNT_W'(1);
						used_q    <= used_q + 1'b1;
					end
				end
				S_CPY_WR: begin
					end_q <= end_q + 1'b1;
					i_q   <= i_q + 1'b1;
				end
				S_DONE: begin
					if (done_go) begin
						out_valid_q      <= 1'b1;
						string_index     <= res_idx_q;
						status           <= res_st_q;
						occurrence_count <= res_cnt_q;
						used_bytes       <= end_q;
						read_byte        <= res_rb_q;
						// staging always empties after an end request
						if (op_q == OP_END) begin
							hash_q <= '0;
							len_q  <= '0;
							pos7_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	sdht_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_str_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	sdht_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_stage_mem (
		.clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(data_byte),
		.raddr(stg_raddr), .rdata(stg_rdata)
	);

	sdht_ram #(.WIDTH(ENT_W), .DEPTH(HASH_BUCKETS)) u_bucket_mem (
		.clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
		.raddr(bkt_raddr), .rdata(bkt_rdata)
	);

	sdht_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_entry_mem (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.raddr(ent_raddr), .rdata(ent_rdata)
	);

`ifndef SYNTHESIS
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= ENT_W'(1) && used_q <= ENT_W'(TABLE_ENTRIES))
		else $error("entry count out of range");
	a_end_range: assert property (@(posedge clk) disable iff (!arst_n)
		end_q >= END_W'(2) && end_q <= END_W'(MEM_BYTES))
		else $error("memory end out of range");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN + 1))
		else $error("staged length out of range");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done");
	a_insert_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR_HDR |-> used_q < ENT_W'(TABLE_ENTRIES))
		else $error("insert with full table");
`endif
endmodule

// ===== bench/tb_string_dedup_hash_table.sv =====
// self-checking testbench for the string dedup hash table
module tb_string_dedup_hash_table;
	import sdht_pkg::*;

	typedef struct {
		int unsigned idx;
		int unsigned st;
		int unsigned cnt;
		int unsigned used;
		int unsigned rb;
	} intern_result_t;

	// in-order model of the interning table plus the queue of awaited results
	class intern_scoreboard;
		bit [7:0]    mem [MEM_BYTES];
		bit          written [MEM_BYTES];
		int unsigned ent_len [TABLE_ENTRIES];
		int unsigned ent_off [TABLE_ENTRIES];
		int unsigned ent_link [TABLE_ENTRIES];
		int unsigned ent_cnt [TABLE_ENTRIES];
		int unsigned head [HASH_BUCKETS];
		bit [7:0]    stage [MAX_LEN];
		int unsigned shifts [7] = '{0, 8, 16, 24, 4, 12, 20};
		int unsigned n_used, mem_end, stage_len, high_water;
		bit [31:0]   hash;
		intern_result_t awaited [$];
		int          errors, n_checked;
		int          n_status [5];

		function void clear_table();
			foreach (head[i]) head[i] = 0;
			mem[0] = HDR_BYTE;
			mem[1] = 8'h00;
			written[0] = 1;
			written[1] = 1;
			n_used = 1;
			mem_end = 2;
			hash = 0;
			stage_len = 0;
		endfunction

		function new();
			high_water = 2;
			clear_table();
		endfunction

		function void put_byte(bit [7:0] b);
			mem[mem_end] = b;
			written[mem_end] = 1;
			mem_end++;
			if (mem_end > high_water) high_water = mem_end;
		endfunction

		function bit same_as_staged(int unsigned e);
			if (ent_len[e] != stage_len) return 0;
			for (int unsigned i = 0; i < stage_len; i++)
				if (ent_off[e] + i >= MEM_BYTES || mem[ent_off[e] + i] != stage[i]) return 0;
			return 1;
		endfunction

		function intern_result_t end_string();
			intern_result_t r;
			int unsigned bkt, e, v;
			r = '{0, 0, 0, 0, 0};
			if (stage_len > MAX_LEN) begin
				r.st = ST_LONG;
				return r;
			end
			bkt = hash % HASH_BUCKETS;
			e = head[bkt];
			// walk the chain, newest entry first
			while (e != 0) begin
				if (same_as_staged(e)) begin
					if (ent_cnt[e] < 65535) ent_cnt[e]++;
					r.idx = e;
					r.st = ST_FOUND;
					r.cnt = ent_cnt[e];
					return r;
				end
				e = ent_link[e];
			end
			if (n_used >= TABLE_ENTRIES) begin
				r.st = ST_TFULL;
				return r;
			end
			if (stage_len + HDR_SLACK > MEM_BYTES - mem_end) begin
				r.st = ST_MFULL;
				return r;
			end
			e = n_used++;
			ent_len[e] = stage_len;
			ent_cnt[e] = 1;
			ent_link[e] = head[bkt];
			head[bkt] = e;
			put_byte(HDR_BYTE);
			v = stage_len;
			while (v > VAR_MASK) begin
				put_byte((v & VAR_MASK) | VAR_MORE);
				v = v >> 7;
			end
			put_byte(v);
			ent_off[e] = mem_end;
			for (int unsigned i = 0; i < stage_len; i++) put_byte(stage[i]);
			r.idx = e;
			r.st = ST_NEW;
			r.cnt = 1;
			return r;
		endfunction

		// update the model for one accepted request
		function void note_request(bit [1:0] op, bit [7:0] b, bit [15:0] addr);
			intern_result_t r;
			case (op)
				OP_CLEAR: clear_table();
				OP_APPEND: begin
					if (b != 0 && stage_len <= MAX_LEN) begin
						if (stage_len < MAX_LEN) begin
							stage[stage_len] = b;
							hash = hash + (32'(b) << shifts[stage_len % 7]);
						end
						stage_len++;
					end
				end
				OP_END: begin
					r = end_string();
					hash = 0;
					stage_len = 0;
					r.used = mem_end;
					awaited.push_back(r);
				end
				OP_READ: begin
					r = '{0, 0, 0, mem_end, mem[addr]};
					awaited.push_back(r);
				end
			endcase
		endfunction

		function void check_result(int unsigned idx, int unsigned st, int unsigned cnt,
				int unsigned used, int unsigned rb);
			intern_result_t x;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: index %0d status %0d", idx, st);
				errors++;
				return;
			end
			x = awaited.pop_front();
			n_checked++;
			if (x.st < 5) n_status[x.st]++;
			if (idx != x.idx) begin
				$error("string_index expected %0d actual %0d", x.idx, idx);
				errors++;
			end
			if (st != x.st) begin
				$error("status expected %0d actual %0d", x.st, st);
				errors++;
			end
			if (cnt != x.cnt) begin
				$error("occurrence_count expected %0d actual %0d", x.cnt, cnt);
				errors++;
			end
			if (used != x.used) begin
				$error("used_bytes expected %0d actual %0d", x.used, used);
				errors++;
			end
			if (rb != x.rb) begin
				$error("read_byte expected %0d actual %0d", x.rb, rb);
				errors++;
			end
		endfunction
	endclass

	localparam longint CYCLE_LIMIT = 6000000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       opcode;
	logic [7:0]       data_byte;
	logic [15:0]      read_address;
	logic             out_valid;
	logic             out_stall;
	logic [IDX_W-1:0] string_index;
	logic [2:0]       status;
	logic [15:0]      occurrence_count;
	logic [END_W-1:0] used_bytes;
	logic [7:0]       read_byte;

	intern_scoreboard sb;
	int     send_idle_pct;   // percent chance, drawn until it fails, that the sender idles before a request
	int     recv_idle_pct;   // chance per cycle that the receiver stalls
	int     hold_cycles;     // long receiver hold-off, counted down by the receiver
	longint cycles;
	int     n_requests;

	// pool of strings reused so that lookups hit existing entries
	bit [7:0] pool [24][$];

	string_dedup_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.data_byte(data_byte),
		.read_address(read_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.string_index(string_index),
		.status(status),
		.occurrence_count(occurrence_count),
		.used_bytes(used_bytes),
		.read_byte(read_byte)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: the block includes a full bucket sweep per clear, so be generous
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: check on every accepted result, then pick next cycle's stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				sb.check_result(string_index, status, occurrence_count, used_bytes, read_byte);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// one request through the input handshake, with random leading gaps
	task automatic send(input logic [1:0] op, input logic [7:0] b, input logic [15:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= b;
		read_address <= addr;
		do @(posedge clk); while (in_stall);
		sb.note_request(op, b, addr);
		n_requests++;
	endtask

	task automatic send_string(input bit [7:0] s [$]);
		foreach (s[i]) send(OP_APPEND, s[i], 16'($urandom));
		send(OP_END, 8'($urandom), 16'($urandom));
	endtask

	task automatic send_read_any();
		send(OP_READ, 8'($urandom), 16'($urandom_range(sb.high_water - 1)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	function automatic void random_pool_entry(int k);
		int n;
		int pick;
		pool[k] = {};
		pick = $urandom_range(99);
		// mostly short strings, a few mid-size, now and then near or over MAX_LEN
		if (pick < 70) n = $urandom_range(6);
		else if (pick < 95) n = $urandom_range(40);
		else n = $urandom_range(MAX_LEN + 4, MAX_LEN - 2);
		repeat (n) pool[k].push_back(8'($urandom_range(255, 1)));
	endfunction

	task automatic random_phase(input int n_items);
		int start;
		int r;
		bit [7:0] s [$];
		start = n_requests;
		while (n_requests - start < n_items) begin
			r = $urandom_range(999);
			if (r < 5) begin
				send(OP_CLEAR, 8'($urandom), 16'($urandom));
			end else if (r < 130) begin
				send_read_any();
			end else if (r < 160) begin
				// stray end or append noise, including a zero byte
				send(r < 145 ? OP_END : OP_APPEND, r < 150 ? 8'h00 : 8'($urandom), 16'($urandom));
			end else begin
				s = pool[$urandom_range(23)];
				// sometimes freshen the pool or slip in a zero byte
				if ($urandom_range(9) == 0) random_pool_entry($urandom_range(23));
				if (s.size() > 0 && $urandom_range(19) == 0)
					s.insert($urandom_range(s.size() - 1), 8'h00);
				send_string(s);
			end
		end
	endtask

	initial begin
		bit [7:0] s [$];
		int k;
		sb = new();
		cycles = 0;
		n_requests = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_valid = 1'b0;
		opcode = OP_READ;
		data_byte = 8'h00;
		read_address = 16'h0000;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (k = 0; k < 24; k++) random_pool_entry(k);

		// directed: reserved bytes, empty string, hit, zero byte, extremes
		send(OP_READ, 8'h00, 16'd0);
		send(OP_READ, 8'hff, 16'd1);
		send_string(s);                        // empty string stored, never entry 0
		send_string(s);
		send_string({8'h01});
		send_string({8'hff});
		send_string({8'h01, 8'h00});           // zero byte ignored: found again
		send(OP_READ, 8'h00, 16'd2);
		send(OP_READ, 8'h00, 16'd4);
		s = {};
		repeat (MAX_LEN + 3) s.push_back(8'($urandom_range(255, 1)));
		send_string(s);                        // too long
		s = s[0:MAX_LEN-1];
		send_string(s);                        // exactly MAX_LEN, two-byte length field
		s = s[0:127];
		send_string(s);
		s = s[0:126];
		send_string(s);                        // one-byte length field limit
		send_read_any();
		send(OP_CLEAR, 8'h00, 16'hffff);
		send_string({8'h01});
		send(OP_READ, 8'h00, 16'd1);

		// random traffic under four idling patterns
		send_idle_pct = 13;
		recv_idle_pct = 59;
		random_phase(100);
		hold_cycles = 400;                     // receiver holds while requests keep coming
		random_phase(100);
		wait_drained();                        // sender pauses until all results are back
		send_idle_pct = 59;
		recv_idle_pct = 13;
		random_phase(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(100);

		wait_drained();
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d results checked", n_requests, sb.n_checked);
		$display("status mix: new %0d found %0d table full %0d memory full %0d too long %0d",
			sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3], sb.n_status[4]);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sdht_pkg.sv
src/sdht_ram.sv
src/string_dedup_hash_table.sv
bench/tb_string_dedup_hash_table.sv
